@@ hdl/gmp_pkg.sv @@
// Shared types and constants for the grid best-energy path block.
package gmp_pkg;

  localparam int MAX_GRID   = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_GRID);
  localparam int SIZE_W     = 7;
  localparam int CELL_W     = 17;
  localparam int COST_W     = 16;
  localparam int ENERGY_W   = 31;

  localparam logic [COST_W-1:0]  VALUE_MAX  = COST_W'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [IDX_W-1:0]   LAST_RESET = IDX_W'(MAX_GRID - 1);
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_value;
    logic [COST_W-1:0]        right_cost;
    logic [COST_W-1:0]        down_cost;
  } cell_in_t;

  typedef struct packed {
    logic                reachable;
    logic [ENERGY_W-1:0] best_energy;
  } result_t;

  // One line buffer entry: the previous row's result at a column.
  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                reach;
    logic [COST_W-1:0]   down_cost;
  } above_t;

  // Position flags of the cell under evaluation.
  typedef struct packed {
    logic first;
    logic has_left;
    logic has_above;
  } cell_ctl_t;

endpackage

@@ hdl/gmp_line_buf.sv @@
// Line buffer holding the previous row's results, one entry per column.
module gmp_line_buf (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [gmp_pkg::IDX_W-1:0] rd_addr_i,
  output gmp_pkg::above_t           rd_data_o,
  input  logic                      wr_en_i,
  input  logic [gmp_pkg::IDX_W-1:0] wr_addr_i,
  input  gmp_pkg::above_t           wr_data_i
);

  gmp_pkg::above_t mem_q [gmp_pkg::MAX_GRID];
  gmp_pkg::above_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/gmp_cell_calc.sv @@
// Best-energy evaluation of one cell from its left and upper neighbors.
module gmp_cell_calc (
  input  gmp_pkg::cell_ctl_t               ctl_i,
  input  logic signed [gmp_pkg::CELL_W-1:0] cell_value_i,
  input  logic [gmp_pkg::ENERGY_W-1:0]     left_energy_i,
  input  logic                             left_reach_i,
  input  logic [gmp_pkg::COST_W-1:0]       left_cost_i,
  input  gmp_pkg::above_t                  above_i,
  output logic                             reach_o,
  output logic [gmp_pkg::ENERGY_W-1:0]     energy_o
);

  localparam int CAND_W = gmp_pkg::ENERGY_W + 2;
  localparam int SUM_W  = CAND_W + 1;

  logic                          blocked;
  logic [gmp_pkg::COST_W-1:0]    value;
  logic signed [CAND_W-1:0]      left_cand;
  logic signed [CAND_W-1:0]      up_cand;
  logic signed [CAND_W-1:0]      best;
  logic                          have_left;
  logic                          have_up;
  logic signed [SUM_W-1:0]       sum;
  logic                          sum_over;

  assign blocked = cell_value_i[gmp_pkg::CELL_W-1];

  always_comb begin
    value = cell_value_i[gmp_pkg::COST_W-1:0];
    if (value > gmp_pkg::VALUE_MAX) begin
      value = gmp_pkg::VALUE_MAX;
    end
  end

  assign left_cand = $signed({2'b00, left_energy_i})
                   - $signed({(CAND_W-gmp_pkg::COST_W)'(0), left_cost_i});
  assign up_cand   = $signed({2'b00, above_i.energy})
                   - $signed({(CAND_W-gmp_pkg::COST_W)'(0), above_i.down_cost});

  assign have_left = ctl_i.has_left & left_reach_i;
  assign have_up   = ctl_i.has_above & above_i.reach;

  // Take the upper arrival when it is the only one or strictly better.
  assign best = (have_up && (!have_left || (up_cand > left_cand))) ? up_cand : left_cand;

  assign sum = {best[CAND_W-1], best}
             + $signed({(SUM_W-gmp_pkg::COST_W)'(0), value});
  assign sum_over = !sum[SUM_W-1] && (sum[SUM_W-2:gmp_pkg::ENERGY_W] != '0);

  always_comb begin
    reach_o  = 1'b0;
    energy_o = '0;
    if (!blocked) begin
      if (ctl_i.first) begin
        reach_o  = 1'b1;
        energy_o = gmp_pkg::ENERGY_W'(value);
      end else if ((have_left || have_up) && !sum[SUM_W-1]) begin
        reach_o  = 1'b1;
        energy_o = sum_over ? gmp_pkg::ENERGY_MAX : sum[gmp_pkg::ENERGY_W-1:0];
      end
    end
  end

endmodule

@@ hdl/grid_max_path_edge_cost_dp.sv @@
// Top level of the grid best-energy path block.
// Cells enter in row-major order, one per request, and the block takes one cell every
// cycle unless stalled: on acceptance the previous row's entry for the column is read
// into a register from the 64-entry line buffer; in the next cycle the cell is evaluated
// against that entry and the left-neighbor registers, then written back. The result of
// the bottom-right cell passes the evaluation stage register, then the output register;
// only that cell produces a result. The input stalls only while a finished result is
// held in the output register and the next result would need it. A write on cfg_we_i
// restarts the grid at the top-left cell; size 0 acts as 1, anything above 64 as 64.
module grid_max_path_edge_cost_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  gmp_pkg::cell_in_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gmp_pkg::result_t           out_data_o,
  input  logic                       cfg_we_i,
  input  logic [gmp_pkg::SIZE_W-1:0] cfg_data_i
);

  logic [gmp_pkg::IDX_W-1:0]    last_q;
  logic [gmp_pkg::IDX_W-1:0]    row_q, row_d;
  logic [gmp_pkg::IDX_W-1:0]    col_q, col_d;
  logic                         s1_valid_q;
  gmp_pkg::cell_in_t            s1_data_q;
  gmp_pkg::cell_ctl_t           s1_ctl_q;
  logic [gmp_pkg::IDX_W-1:0]    s1_col_q;
  logic                         s1_last_q;
  logic [gmp_pkg::ENERGY_W-1:0] left_energy_q;
  logic                         left_reach_q;
  logic [gmp_pkg::COST_W-1:0]   left_cost_q;
  logic                         out_valid_q;
  gmp_pkg::result_t             out_q;

  logic                         in_acc;
  logic                         out_free;
  logic                         s1_go;
  gmp_pkg::cell_ctl_t           ctl_d;
  gmp_pkg::above_t              above;
  gmp_pkg::above_t              wr_entry;
  logic                         reach;
  logic [gmp_pkg::ENERGY_W-1:0] energy;
  logic [gmp_pkg::IDX_W-1:0]    last_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  assign ctl_d.first     = (row_q == '0) && (col_q == '0);
  assign ctl_d.has_left  = (col_q != '0);
  assign ctl_d.has_above = (row_q != '0);

  // Advance the raster position.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_q == last_q) begin
      col_d = '0;
      row_d = (row_q == last_q) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_comb begin
    if (cfg_data_i == '0) begin
      last_d = '0;
    end else if (int'(cfg_data_i) >= gmp_pkg::MAX_GRID) begin
      last_d = gmp_pkg::LAST_RESET;
    end else begin
      last_d = gmp_pkg::IDX_W'(cfg_data_i - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= gmp_pkg::LAST_RESET;
      row_q        <= '0;
      col_q        <= '0;
      s1_valid_q   <= 1'b0;
      left_energy_q <= '0;
      left_reach_q <= 1'b0;
      left_cost_q  <= '0;
      out_valid_q  <= 1'b0;
    end else if (cfg_we_i) begin
      last_q       <= last_d;
      row_q        <= '0;
      col_q        <= '0;
      left_energy_q <= '0;
      left_reach_q <= 1'b0;
      left_cost_q  <= '0;
    end else begin
      if (in_acc) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        left_energy_q <= energy;
        left_reach_q  <= reach;
        left_cost_q   <= s1_data_q.right_cost;
      end
      if (s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
      s1_ctl_q  <= ctl_d;
      s1_col_q  <= col_q;
      s1_last_q <= (row_q == last_q) && (col_q == last_q);
    end
    if (s1_go && s1_last_q) begin
      out_q.reachable   <= reach;
      out_q.best_energy <= energy;
    end
  end

  assign wr_entry.energy    = energy;
  assign wr_entry.reach     = reach;
  assign wr_entry.down_cost = s1_data_q.down_cost;

  // A write and a read meet at one column only when the grid is a single cell wide,
  // and then the upper entry is never used.
  gmp_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (above),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_entry)
  );

  gmp_cell_calc u_cell_calc (
    .ctl_i         (s1_ctl_q),
    .cell_value_i  (s1_data_q.cell_value),
    .left_energy_i (left_energy_q),
    .left_reach_i  (left_reach_q),
    .left_cost_i   (left_cost_q),
    .above_i       (above),
    .reach_o       (reach),
    .energy_o      (energy)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/gmp_checker.sv @@
// Port-level checks for the grid best-energy path block, bound to its top level.
module gmp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input gmp_pkg::cell_in_t          in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input gmp_pkg::result_t           out_data_o,
  input logic                       cfg_we_i,
  input logic [gmp_pkg::SIZE_W-1:0] cfg_data_i
);

  // Hold a pending result until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reachable |-> out_data_o.best_energy == '0)
    else $error("unreachable result with nonzero energy");

  // A fresh result comes from an accepted cell, registered in the evaluation stage and then in the output register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching request");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

endmodule

bind grid_max_path_edge_cost_dp gmp_checker u_gmp_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the grid best-energy path block.
module tb_top;

  localparam int HOLD_LONG      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_CELLS   = 500;
  localparam int REPORT_LIMIT   = 10;

  localparam int CELL_W   = gmp_pkg::CELL_W;
  localparam int COST_W   = gmp_pkg::COST_W;
  localparam int SIZE_W   = gmp_pkg::SIZE_W;
  localparam int ENERGY_W = gmp_pkg::ENERGY_W;
  localparam int MAX_GRID = gmp_pkg::MAX_GRID;
  localparam logic [COST_W-1:0]   VALUE_MAX  = gmp_pkg::VALUE_MAX;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = gmp_pkg::ENERGY_MAX;

  localparam logic signed [CELL_W-1:0] BLOCKED = -1;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  gmp_pkg::cell_in_t in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  gmp_pkg::result_t  out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0] cfg_data_i  = '0;

  grid_max_path_edge_cost_dp i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the block's state.
  logic [SIZE_W-1:0]   size_reg;
  int unsigned         row_pos;
  int unsigned         col_pos;
  logic [ENERGY_W-1:0] above_nrg [MAX_GRID];
  logic                above_ok  [MAX_GRID];
  logic [COST_W-1:0]   above_dc  [MAX_GRID];
  logic [ENERGY_W-1:0] left_nrg;
  logic                left_ok;
  logic [COST_W-1:0]   left_rc;

  gmp_pkg::cell_in_t grid_cells_q[$];
  gmp_pkg::result_t  grid_results_q[$];
  gmp_pkg::result_t  oldest_result;

  bit idle_en;
  bit long_hold_req;
  bit long_hold_done;
  int send_gap;
  int sink_hold;
  int quiet_cycles;
  int mismatches;

  function automatic void restart_walk();
    row_pos  = 0;
    col_pos  = 0;
    left_nrg = '0;
    left_ok  = 1'b0;
    left_rc  = '0;
  endfunction

  // Evaluate one cell against its left and upper neighbors, then advance the position.
  function automatic void update_path_energy(gmp_pkg::cell_in_t c);
    int unsigned      side;
    int unsigned      col;
    longint           value;
    longint           best;
    longint           up;
    longint           nrg;
    bit               ok;
    bit               have;
    gmp_pkg::result_t res;
    side  = (size_reg == 0) ? 1 : ((size_reg > MAX_GRID) ? MAX_GRID : size_reg);
    col   = (col_pos >= MAX_GRID) ? MAX_GRID - 1 : col_pos;
    value = longint'(c.cell_value[COST_W-1:0]);
    if (value > longint'(VALUE_MAX)) value = longint'(VALUE_MAX);
    ok   = 1'b0;
    have = 1'b0;
    nrg  = 0;
    best = 0;
    if (!c.cell_value[CELL_W-1]) begin
      if (row_pos == 0 && col == 0) begin
        ok  = 1'b1;
        nrg = value;
      end else begin
        if (col > 0 && left_ok) begin
          best = longint'(left_nrg) - longint'(left_rc);
          have = 1'b1;
        end
        if (row_pos > 0 && above_ok[col]) begin
          up = longint'(above_nrg[col]) - longint'(above_dc[col]);
          if (!have || up > best) best = up;
          have = 1'b1;
        end
        if (have) begin
          nrg = value + best;
          ok  = (nrg >= 0);
        end
      end
    end
    if (!ok) nrg = 0;
    if (nrg > longint'(ENERGY_MAX)) nrg = longint'(ENERGY_MAX);

    above_nrg[col] = nrg[ENERGY_W-1:0];
    above_ok[col]  = ok;
    above_dc[col]  = c.down_cost;
    left_nrg       = nrg[ENERGY_W-1:0];
    left_ok        = ok;
    left_rc        = c.right_cost;

    if (col + 1 >= side) begin
      if (row_pos + 1 >= side) begin
        res.reachable   = ok;
        res.best_energy = nrg[ENERGY_W-1:0];
        grid_results_q = {grid_results_q, res};
        restart_walk();
      end else begin
        row_pos  = row_pos + 1;
        col_pos  = 0;
        left_nrg = '0;
        left_ok  = 1'b0;
        left_rc  = '0;
      end
    end else begin
      col_pos = col + 1;
    end
  endfunction

  function automatic logic [COST_W-1:0] draw_cost(bit benign);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '1;
    if (r < 10) return '0;
    return benign ? COST_W'($urandom_range(0, 30000)) : COST_W'($urandom);
  endfunction

  // Benign cells keep most paths alive; the rest is noise with many blocks and steep costs.
  function automatic gmp_pkg::cell_in_t draw_cell(bit benign);
    gmp_pkg::cell_in_t c;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 4) c.cell_value = BLOCKED;
    else if (r < (benign ? 5 : 20)) c.cell_value = {1'b1, COST_W'($urandom)};
    else if (r < (benign ? 8 : 23)) c.cell_value = {1'b0, VALUE_MAX};
    else if (r < (benign ? 10 : 26)) c.cell_value = '0;
    else c.cell_value = {1'b0, COST_W'($urandom)};
    c.right_cost = draw_cost(benign);
    c.down_cost  = draw_cost(benign);
    return c;
  endfunction

  function automatic void queue_cell(gmp_pkg::cell_in_t c);
    grid_cells_q = {grid_cells_q, c};
  endfunction

  function automatic void push_cell(int value, int rcost, int dcost);
    gmp_pkg::cell_in_t c;
    c.cell_value = CELL_W'(value);
    c.right_cost = COST_W'(rcost);
    c.down_cost  = COST_W'(dcost);
    queue_cell(c);
  endfunction

  // Wait until every request is taken and every result is back, then let the pipe drain.
  task automatic settle();
    while (grid_cells_q.size() != 0 || in_valid_i || grid_results_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    size_reg = value;
    restart_walk();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) update_path_energy(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (idle_en && grid_cells_q.size() != 0 && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else if (grid_cells_q.size() != 0) begin
          in_data_i  <= grid_cells_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (grid_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result reachable=%0b best_energy=%0d", $realtime,
                     out_data_o.reachable, out_data_o.best_energy);
        end else begin
          oldest_result = grid_results_q.pop_front();
          if (out_data_o.reachable !== oldest_result.reachable ||
              out_data_o.best_energy !== oldest_result.best_energy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: expected reachable=%0b energy=%0d, got reachable=%0b energy=%0d",
                       $realtime, oldest_result.reachable, oldest_result.best_energy,
                       out_data_o.reachable, out_data_o.best_energy);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        sink_hold = HOLD_LONG;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        sink_hold = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int          random_cells;
    int          cfg;
    int          side;
    int          count;
    int unsigned r;
    bit          benign;
    idle_en        = 1'b1;
    long_hold_req  = 1'b0;
    long_hold_done = 1'b0;
    quiet_cycles   = 0;
    mismatches     = 0;
    size_reg       = SIZE_W'(MAX_GRID);
    restart_walk();
    for (int i = 0; i < MAX_GRID; i++) begin
      above_nrg[i] = '0;
      above_ok[i]  = 1'b0;
      above_dc[i]  = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset size: the first row and the start of the second, then drop it with a write.
    repeat (MAX_GRID + 2) queue_cell(draw_cell(1'b1));
    settle();

    write_size(1);
    push_cell(0, 65535, 65535);
    push_cell(int'(VALUE_MAX), 0, 0);
    push_cell(BLOCKED, 1, 1);
    push_cell(-2, 0, 65535);
    push_cell(-65536, 65535, 0);
    push_cell(1, 12345, 54321);
    settle();

    // Size zero acts as one.
    write_size(0);
    push_cell(12345, 7, 9);
    push_cell(BLOCKED, 0, 0);
    settle();

    write_size(2);
    // Blocked start: nothing is reachable.
    push_cell(BLOCKED, 0, 0);
    push_cell(100, 0, 0);
    push_cell(100, 0, 0);
    push_cell(100, 0, 0);
    // Left arrival wins; the top-right cell survives a negative arrival.
    push_cell(1000, 5000, 10);
    push_cell(int'(VALUE_MAX), 0, 65535);
    push_cell(7, 0, 0);
    push_cell(0, 0, 0);
    // Costs drive every arrival negative.
    push_cell(10, 65535, 65535);
    push_cell(5, 0, 0);
    push_cell(5, 0, 0);
    push_cell(int'(VALUE_MAX), 0, 0);
    // Upper arrival wins.
    push_cell(0, 0, 0);
    push_cell(int'(VALUE_MAX), 0, 100);
    push_cell(1, 0, 0);
    push_cell(7, 0, 0);
    settle();

    // Hold off the receiver while one-cell grids keep coming, so the input stalls.
    write_size(1);
    long_hold_req = 1'b1;
    repeat (40) queue_cell(draw_cell(1'b1));
    settle();

    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      r   = $urandom_range(0, 19);
      cfg = (r == 0) ? 0 : ((r < 16) ? $urandom_range(1, 6) : $urandom_range(7, 10));
      side  = (cfg == 0) ? 1 : cfg;
      count = side * side * ((side <= 6) ? $urandom_range(1, 3) : 1);
      // Leave a grid unfinished now and then; the next write drops it.
      if (side > 1 && $urandom_range(0, 5) == 0) count += $urandom_range(1, side * side - 1);
      benign  = ($urandom_range(0, 4) != 0);
      idle_en = ($urandom_range(0, 3) != 0);
      write_size(SIZE_W'(cfg));
      repeat (count) queue_cell(draw_cell(benign));
      random_cells += count;
      settle();
    end

    // Oversized: run into the second row of the largest grid, then drop it with a write.
    idle_en = 1'b1;
    write_size('1);
    repeat (MAX_GRID + 2) queue_cell(draw_cell(1'b1));
    settle();

    idle_en = 1'b0;
    write_size(3);
    repeat (27) queue_cell(draw_cell(1'b1));
    settle();

    if (mismatches == 0 && grid_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
